[hw/rtl/bblf_pkg.sv]
package bblf_pkg;

   // sizing
   localparam int MAX_RADIUS = 31;
   localparam int PIXEL_BITS = 16;

   localparam int STORE_DEPTH = 2 * MAX_RADIUS + 1;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int RAM_DEPTH   = 1 << ADDR_BITS;
   localparam int RADIUS_BITS = $clog2(MAX_RADIUS + 1);
   localparam int CNT_BITS    = RADIUS_BITS + 1;
   localparam int POS_BITS    = 6;
   localparam int POS_LIMIT   = 63;
   localparam int D_BITS      = POS_BITS + 1;
   localparam int SUM_BITS    = PIXEL_BITS + ADDR_BITS;

   // fixed point
   localparam int FRAC_BITS   = 16;
   localparam int RECIP_BITS  = 17;
   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
   localparam int RND_BITS    = PROD_BITS + 1;

   // register file
   localparam int RADIUS_FIELD_BITS = 5;
   localparam int CSR_DATA_BITS     = 17;
   localparam int CSR_INDEX_BITS    = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIUS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECIP  = 1'd1;
   localparam logic [RECIP_BITS-1:0]     RECIP_RESET = RECIP_BITS'(1 << FRAC_BITS);

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_in;
      logic                  line_end_in;
   } req_beat_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_out;
      logic                  line_end_out;
   } rsp_beat_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic start_out;
      logic issue;
      logic mul;
      logic round;
      logic next_out;
   } bblf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit_any;
      logic terms_last;
      logic more_out;
      logic out_busy;
   } bblf_status_type;

endpackage

[hw/rtl/bblf_ram.sv]
module bblf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bblf_ctrl.sv]
module bblf_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output bblf_pkg::bblf_cmd_type    cmd,
   input  bblf_pkg::bblf_status_type status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PLAN,
      S_SUM,
      S_ACC,
      S_MUL,
      S_RND
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;
   logic      accept;

   assign accept    = req_valid && !stall_ff;
   assign req_stall = stall_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            if (status.emit_any) begin
               cmd.start_out = 1'b1;
               state_in      = S_SUM;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SUM: begin
            cmd.issue = 1'b1;
            if (status.terms_last) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_RND;
         end
         S_RND: begin
            if (!status.out_busy) begin
               cmd.round = 1'b1;
               if (status.more_out) begin
                  cmd.next_out = 1'b1;
                  state_in     = S_SUM;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign stall_in = (state_in != S_IDLE);

   // state and input stall
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

endmodule

[hw/rtl/bblf_datapath.sv]
module bblf_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_wr_en,
   input  logic [bblf_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [bblf_pkg::CSR_DATA_BITS-1:0]       csr_wr_data,
   input  bblf_pkg::req_beat_type                   req_beat,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output bblf_pkg::rsp_beat_type                   rsp_beat,
   input  bblf_pkg::bblf_cmd_type                   cmd,
   output bblf_pkg::bblf_status_type                status
);

   typedef enum logic [1:0] {
      SRC_RAM,
      SRC_NEWEST,
      SRC_FIRST
   } src_type;

   // configuration
   logic [bblf_pkg::RADIUS_FIELD_BITS-1:0] radius_ff, radius_in;
   logic [bblf_pkg::RECIP_BITS-1:0]        recip_ff, recip_in;
   logic [bblf_pkg::RADIUS_BITS-1:0]       r_eff;

   // line state
   logic [bblf_pkg::ADDR_BITS-1:0]  wp_ff, wp_in;
   logic [bblf_pkg::PIXEL_BITS-1:0] newest_ff, newest_in;
   logic [bblf_pkg::PIXEL_BITS-1:0] first_ff, first_in;
   logic [bblf_pkg::POS_BITS-1:0]   pos_ff, pos_in;
   logic [bblf_pkg::POS_BITS-1:0]   item_pos_ff, item_pos_in;
   logic                            last_item_ff, last_item_in;

   // window walk
   logic [bblf_pkg::RADIUS_BITS-1:0] off_ff, off_in, off_start, off_next;
   logic signed [bblf_pkg::D_BITS-1:0] d_ff, d_in;
   logic [bblf_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in, cnt_start;
   logic                             rd_valid_ff, rd_valid_in;
   src_type                          sel_ff, sel_in;
   logic [bblf_pkg::ADDR_BITS-1:0]   rd_addr;
   logic [bblf_pkg::PIXEL_BITS-1:0]  rd_data;
   logic [bblf_pkg::PIXEL_BITS-1:0]  term;
   logic [bblf_pkg::SUM_BITS-1:0]    sum_ff, sum_in;
   logic [bblf_pkg::PROD_BITS-1:0]   prod_ff, prod_in;

   // output stage
   logic [bblf_pkg::RND_BITS-1:0]              rnd;
   logic [bblf_pkg::RND_BITS-bblf_pkg::FRAC_BITS-1:0] quo;
   logic [bblf_pkg::PIXEL_BITS-1:0]            pix_sat;
   logic                                       rsp_valid_ff, rsp_valid_in;
   bblf_pkg::rsp_beat_type                     rsp_beat_ff, rsp_beat_in;

   // register writes
   always_comb begin
      radius_in = radius_ff;
      recip_in  = recip_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bblf_pkg::CSR_RADIUS:
               radius_in = csr_wr_data[bblf_pkg::RADIUS_FIELD_BITS-1:0];
            bblf_pkg::CSR_RECIP:
               recip_in = csr_wr_data[bblf_pkg::RECIP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign r_eff = (radius_ff > bblf_pkg::RADIUS_FIELD_BITS'(bblf_pkg::MAX_RADIUS))
                  ? bblf_pkg::RADIUS_BITS'(bblf_pkg::MAX_RADIUS)
                  : radius_ff[bblf_pkg::RADIUS_BITS-1:0];

   // take in one pixel beat
   always_comb begin
      wp_in        = wp_ff;
      newest_in    = newest_ff;
      first_in     = first_ff;
      pos_in       = pos_ff;
      item_pos_in  = item_pos_ff;
      last_item_in = last_item_ff;
      if (cmd.load) begin
         wp_in        = wp_ff + 1'b1;
         newest_in    = req_beat.pixel_in;
         item_pos_in  = pos_ff;
         last_item_in = req_beat.line_end_in;
         if (pos_ff == '0) begin
            first_in = req_beat.pixel_in;
         end
         if (req_beat.line_end_in) begin
            pos_in = '0;
         end else if (pos_ff != bblf_pkg::POS_BITS'(bblf_pkg::POS_LIMIT)) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // first output offset: r normally, fewer on a short line at its end
   always_comb begin
      if (last_item_ff && (item_pos_ff < bblf_pkg::POS_BITS'(r_eff))) begin
         off_start = item_pos_ff[bblf_pkg::RADIUS_BITS-1:0];
      end else begin
         off_start = r_eff;
      end
   end

   assign off_next  = off_ff - 1'b1;
   assign cnt_start = {r_eff, 1'b0};

   // walk the window terms, one read per cycle
   always_comb begin
      off_in      = off_ff;
      d_in        = d_ff;
      cnt_in      = cnt_ff;
      rd_valid_in = 1'b0;
      sel_in      = sel_ff;
      rd_addr     = wp_ff - d_ff[bblf_pkg::ADDR_BITS-1:0];
      if (cmd.start_out) begin
         off_in = off_start;
         d_in   = $signed(bblf_pkg::D_BITS'(off_start)) - $signed(bblf_pkg::D_BITS'(r_eff));
         cnt_in = cnt_start;
      end else if (cmd.next_out) begin
         off_in = off_next;
         d_in   = $signed(bblf_pkg::D_BITS'(off_next)) - $signed(bblf_pkg::D_BITS'(r_eff));
         cnt_in = cnt_start;
      end else if (cmd.issue) begin
         d_in        = d_ff + $signed(bblf_pkg::D_BITS'(1));
         cnt_in      = cnt_ff - 1'b1;
         rd_valid_in = 1'b1;
         if (d_ff[bblf_pkg::D_BITS-1]) begin
            sel_in = SRC_NEWEST;
         end else if (d_ff[bblf_pkg::POS_BITS-1:0] > item_pos_ff) begin
            sel_in = SRC_FIRST;
         end else begin
            sel_in = SRC_RAM;
         end
      end
   end

   bblf_ram #(
      .WIDTH (bblf_pkg::PIXEL_BITS),
      .DEPTH (bblf_pkg::RAM_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (wp_in),
      .wr_data (req_beat.pixel_in),
      .rd_en   (cmd.issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // accumulate the selected term
   always_comb begin
      case (sel_ff)
         SRC_NEWEST: term = newest_ff;
         SRC_FIRST:  term = first_ff;
         default:    term = rd_data;
      endcase
      sum_in = sum_ff;
      if (cmd.start_out || cmd.next_out) begin
         sum_in = '0;
      end else if (rd_valid_ff) begin
         sum_in = sum_ff + bblf_pkg::SUM_BITS'(term);
      end
   end

   // scale by the reciprocal
   assign prod_in = cmd.mul ? (bblf_pkg::PROD_BITS'(sum_ff) * bblf_pkg::PROD_BITS'(recip_ff))
                            : prod_ff;

   // round half up and saturate
   assign rnd = bblf_pkg::RND_BITS'(prod_ff)
              + bblf_pkg::RND_BITS'(1 << (bblf_pkg::FRAC_BITS - 1));
   assign quo = rnd[bblf_pkg::RND_BITS-1:bblf_pkg::FRAC_BITS];
   assign pix_sat = (|quo[$bits(quo)-1:bblf_pkg::PIXEL_BITS])
                    ? '1 : quo[bblf_pkg::PIXEL_BITS-1:0];

   // output register
   always_comb begin
      rsp_beat_in  = rsp_beat_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.round) begin
         rsp_beat_in.pixel_out    = pix_sat;
         rsp_beat_in.line_end_out = last_item_ff && (off_ff == '0);
         rsp_valid_in             = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= '0;
         recip_ff     <= bblf_pkg::RECIP_RESET;
         wp_ff        <= '0;
         pos_ff       <= '0;
         first_ff     <= '0;
         sum_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         radius_ff    <= radius_in;
         recip_ff     <= recip_in;
         wp_ff        <= wp_in;
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         sum_ff       <= sum_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      newest_ff    <= newest_in;
      item_pos_ff  <= item_pos_in;
      last_item_ff <= last_item_in;
      off_ff       <= off_in;
      d_ff         <= d_in;
      cnt_ff       <= cnt_in;
      sel_ff       <= sel_in;
      prod_ff      <= prod_in;
      rsp_beat_ff  <= rsp_beat_in;
   end

   assign status.emit_any   = last_item_ff || (item_pos_ff >= bblf_pkg::POS_BITS'(r_eff));
   assign status.terms_last = (cnt_ff == '0);
   assign status.more_out   = last_item_ff && (off_ff != '0);
   assign status.out_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

[hw/rtl/box_blur_line_filter.sv]
// One-dimensional box filter with edge replication over a stream of lines.
// Each result pixel j is the sum of input pixels j-radius..j+radius (indexes
// clamped to the first and last pixel of the line) times the reciprocal in
// Q1.16, rounded half up and saturated. Result j leaves after input j+radius;
// the last pixel of a line flushes all pending results of that line. The
// block takes one pixel beat at a time. The window sum of each result is
// built one term per cycle through the single read port of the 64-entry
// window memory, then multiplied and rounded. A finished result waits in
// an output register, so the next pixel is taken while it is stalled.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this. There is no clearing pass after reset.
module box_blur_line_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bblf_pkg::req_beat_type              req_beat,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bblf_pkg::rsp_beat_type              rsp_beat,
   input  logic                                csr_wr_en,
   input  logic [bblf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bblf_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);

   bblf_pkg::bblf_cmd_type    cmd;
   bblf_pkg::bblf_status_type status;

   // sequencer
   bblf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // window store, sum, scale and output register
   bblf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_beat    (req_beat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat),
      .cmd         (cmd),
      .status      (status)
   );

   // an accepted beat closes the input until its work is done
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not closed after an accepted beat");

   // a rounded result always shows up on the output
   assert property (@(posedge clock) disable iff (reset)
      cmd.round |=> rsp_valid)
      else $error("rounded result did not reach the output");

   // the final term is followed by accumulate and then multiply
   assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && status.terms_last) |=> !cmd.issue ##1 cmd.mul)
      else $error("window sum not followed by multiply");

endmodule
